FILE: src/smie_pkg.sv
// Shared constants for the stack machine instruction executor: memory geometry,
// opcodes, status codes and address check helpers. Depends on nothing.
package smie_pkg;

	localparam int MEM_BYTES = 16384;
	localparam int MEM_WORDS = MEM_BYTES / 4;
	localparam int AW        = $clog2(MEM_WORDS);

	localparam logic [31:0] MEM_BYTES_W = 32'(MEM_BYTES);
	localparam logic [31:0] WORD_LIMIT  = 32'(MEM_BYTES - 4);

	localparam logic [5:0] OP_LEA  = 6'd0;
	localparam logic [5:0] OP_IMM  = 6'd1;
	localparam logic [5:0] OP_JMP  = 6'd2;
	localparam logic [5:0] OP_JZ   = 6'd3;
	localparam logic [5:0] OP_JNZ  = 6'd4;
	localparam logic [5:0] OP_CALL = 6'd5;
	localparam logic [5:0] OP_ENT  = 6'd6;
	localparam logic [5:0] OP_ADJ  = 6'd7;
	localparam logic [5:0] OP_LEV  = 6'd8;
	localparam logic [5:0] OP_LI   = 6'd9;
	localparam logic [5:0] OP_LC   = 6'd10;
	localparam logic [5:0] OP_SI   = 6'd11;
	localparam logic [5:0] OP_SC   = 6'd12;
	localparam logic [5:0] OP_PUSH = 6'd13;
	localparam logic [5:0] OP_XOR  = 6'd14;
	localparam logic [5:0] OP_OR   = 6'd15;
	localparam logic [5:0] OP_AND  = 6'd16;
	localparam logic [5:0] OP_EQ   = 6'd17;
	localparam logic [5:0] OP_NE   = 6'd18;
	localparam logic [5:0] OP_LT   = 6'd19;
	localparam logic [5:0] OP_LE   = 6'd20;
	localparam logic [5:0] OP_GT   = 6'd21;
	localparam logic [5:0] OP_GE   = 6'd22;
	localparam logic [5:0] OP_SHL  = 6'd23;
	localparam logic [5:0] OP_SHR  = 6'd24;
	localparam logic [5:0] OP_ADD  = 6'd25;
	localparam logic [5:0] OP_SUB  = 6'd26;
	localparam logic [5:0] OP_MUL  = 6'd27;
	localparam logic [5:0] OP_DIV  = 6'd28;
	localparam logic [5:0] OP_MOD  = 6'd29;
	localparam logic [5:0] OP_EXIT = 6'd37;

	localparam logic [2:0] ST_RUN     = 3'd0;
	localparam logic [2:0] ST_EXIT    = 3'd1;
	localparam logic [2:0] ST_UNSUP   = 3'd2;
	localparam logic [2:0] ST_DIV0    = 3'd3;
	localparam logic [2:0] ST_BADADDR = 3'd4;
	localparam logic [2:0] ST_HALTED  = 3'd5;

	// A word access must be aligned and lie wholly inside the memory.
	function automatic logic word_ok(input logic [31:0] a);
		word_ok = (a[1:0] == 2'b00) && (a <= WORD_LIMIT);
	endfunction

	function automatic logic byte_ok(input logic [31:0] a);
		byte_ok = a < MEM_BYTES_W;
	endfunction

	function automatic logic [AW-1:0] word_idx(input logic [31:0] a);
		word_idx = a[AW+1:2];
	endfunction

endpackage

FILE: src/smie_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
module smie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: src/stack_machine_instruction_executor.sv
// Top level of the stack machine instruction executor: sequencer, registers,
// shared ALU and divider. Depends on smie_pkg and smie_ram.
//
// Usage. Each input item is one instruction (operation, operand, instr_addr)
// and produces exactly one result item (next_pc, acc_value, status,
// exit_value). Both channels use valid and ready.
// After reset the data memory is swept to zero, one word per cycle, and
// in_ready stays low until the sweep is done. The accumulator and halt flag
// are cleared at once by reset, and the stack and frame pointers are set to
// MEM_BYTES.
// Sequencing. The block handles one instruction at a time over a single port
// data memory and one shared ALU. A register-only instruction goes through
// decode and execute to the done state; each memory read adds a read state,
// and DIV and MOD run a one-bit-per-cycle divider after execute. An item on a
// halted block, or with an unsupported opcode, goes from decode to done.
// in_ready is high only while the block is idle, so a new item is taken only
// once the previous one has been committed as a result.
// Stalling. The result is held in an output register. The block accepts the
// next item while that result waits; it only stalls before committing a new
// result if the previous one has not yet been taken.
// Any fault or EXIT sets the halt flag; from then on every item returns
// status halted until the next reset.
module stack_machine_instruction_executor
	import smie_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  operation,
	input  logic [31:0] operand,
	input  logic [31:0] instr_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] next_pc,
	output logic [31:0] acc_value,
	output logic [2:0]  status,
	output logic [31:0] exit_value
);

	typedef enum logic [8:0] {
		S_CLR  = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_DEC  = 9'b000000100,
		S_RD1  = 9'b000001000,
		S_RD2  = 9'b000010000,
		S_EXEC = 9'b000100000,
		S_DIV  = 9'b001000000,
		S_DFIN = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t state_q;

	logic [AW:0]   clr_q;
	logic [5:0]    op_q;
	logic [31:0]   opd_q, ia_q;
	logic [31:0]   acc_q, sp_q, fp_q;
	logic          halted_q;
	logic [31:0]   w1_q, w2_q;
	logic [31:0]   r_npc_q, r_acc_q, r_sp_q, r_fp_q, r_exv_q;
	logic [2:0]    r_st_q;
	logic [31:0]   rem_q, quo_q, dsr_q;
	logic [4:0]    cnt_q;
	logic          qneg_q, rneg_q;
	logic          out_valid_q;
	logic [31:0]   o_npc_q, o_acc_q, o_exv_q;
	logic [2:0]    o_st_q;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_wdata, ram_rdata;

	logic [31:0]   spm4, npc_seq, alu_res, lc_val, sc_word, opd4;
	logic [32:0]   div_t, div_d;
	logic          commit;

	smie_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign spm4    = sp_q - 32'd4;
	assign opd4    = {opd_q[29:0], 2'b00};
	assign npc_seq = (op_q <= OP_ADJ) ? ia_q + 32'd2 : ia_q + 32'd1;
	assign div_t   = {rem_q, quo_q[31]};
	assign div_d   = div_t - {1'b0, dsr_q};
	assign commit  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == S_IDLE);

	// Byte lane selection for byte loads and the read-modify-write of byte stores.
	always_comb begin
		logic [7:0] b;
		b = 8'h00;
		sc_word = w2_q;
		case (acc_q[1:0])
			2'd0:    b = w1_q[7:0];
			2'd1:    b = w1_q[15:8];
			2'd2:    b = w1_q[23:16];
			default: b = w1_q[31:24];
		endcase
		lc_val = {{24{b[7]}}, b};
		case (w1_q[1:0])
			2'd0:    sc_word[7:0]   = acc_q[7:0];
			2'd1:    sc_word[15:8]  = acc_q[7:0];
			2'd2:    sc_word[23:16] = acc_q[7:0];
			default: sc_word[31:24] = acc_q[7:0];
		endcase
	end

	// The shared ALU: left operand popped from the stack, right operand the accumulator.
	always_comb begin
		case (op_q)
			OP_XOR:  alu_res = w1_q ^ acc_q;
			OP_OR:   alu_res = w1_q | acc_q;
			OP_AND:  alu_res = w1_q & acc_q;
			OP_EQ:   alu_res = {31'd0, w1_q == acc_q};
			OP_NE:   alu_res = {31'd0, w1_q != acc_q};
			OP_LT:   alu_res = {31'd0, $signed(w1_q) < $signed(acc_q)};
			OP_LE:   alu_res = {31'd0, $signed(w1_q) <= $signed(acc_q)};
			OP_GT:   alu_res = {31'd0, $signed(w1_q) > $signed(acc_q)};
			OP_GE:   alu_res = {31'd0, $signed(w1_q) >= $signed(acc_q)};
			OP_SHL:  alu_res = w1_q << acc_q[4:0];
			OP_SHR:  alu_res = 32'($signed(w1_q) >>> acc_q[4:0]);
			OP_ADD:  alu_res = w1_q + acc_q;
			OP_SUB:  alu_res = w1_q - acc_q;
			OP_MUL:  alu_res = w1_q * acc_q;
			default: alu_res = 32'd0;
		endcase
	end

	// Memory port: clearing sweep, reads issued ahead of use, and the single write.
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = word_idx(sp_q);
		ram_wdata = 32'd0;
		unique case (state_q)
			S_CLR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q[AW-1:0];
			end
			S_DEC: begin
				if (op_q == OP_LEV) begin
					ram_addr = word_idx(fp_q);
				end else if (op_q == OP_LI || op_q == OP_LC) begin
					ram_addr = word_idx(acc_q);
				end
			end
			S_RD1: begin
				if (op_q == OP_SC) begin
					ram_addr = word_idx(ram_rdata);
				end else begin
					ram_addr = word_idx(fp_q + 32'd4);
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_CALL: begin
						ram_we    = word_ok(spm4);
						ram_addr  = word_idx(spm4);
						ram_wdata = ia_q + 32'd2;
					end
					OP_ENT: begin
						ram_we    = word_ok(spm4);
						ram_addr  = word_idx(spm4);
						ram_wdata = fp_q;
					end
					OP_PUSH: begin
						ram_we    = word_ok(spm4);
						ram_addr  = word_idx(spm4);
						ram_wdata = acc_q;
					end
					OP_SI: begin
						ram_we    = 1'b1;
						ram_addr  = word_idx(w1_q);
						ram_wdata = acc_q;
					end
					OP_SC: begin
						ram_we    = 1'b1;
						ram_addr  = word_idx(w1_q);
						ram_wdata = sc_word;
					end
					default: ram_we = 1'b0;
				endcase
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			acc_q       <= 32'd0;
			sp_q        <= MEM_BYTES_W;
			fp_q        <= MEM_BYTES_W;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A result taken in the same cycle as a new commit is replaced below.
			if (out_valid_q && out_ready && !commit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(MEM_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= operation;
						opd_q   <= operand;
						ia_q    <= instr_addr;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					// Defaults for a fault; overwritten on the normal path.
					r_npc_q <= ia_q;
					r_acc_q <= acc_q;
					r_sp_q  <= sp_q;
					r_fp_q  <= fp_q;
					r_exv_q <= 32'd0;
					r_st_q  <= ST_RUN;
					if (halted_q) begin
						r_st_q  <= ST_HALTED;
						state_q <= S_DONE;
					end else if ((op_q > OP_MOD && op_q != OP_EXIT)) begin
						r_st_q  <= ST_UNSUP;
						state_q <= S_DONE;
					end else if (op_q >= OP_SI && op_q != OP_PUSH) begin
						// Stack read: binary ops, stores and exit.
						if (!word_ok(sp_q)) begin
							r_st_q  <= ST_BADADDR;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD1;
						end
					end else if (op_q == OP_LEV) begin
						if (!word_ok(fp_q) || !word_ok(fp_q + 32'd4)) begin
							r_st_q  <= ST_BADADDR;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD1;
						end
					end else if (op_q == OP_LI) begin
						if (!word_ok(acc_q)) begin
							r_st_q  <= ST_BADADDR;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD1;
						end
					end else if (op_q == OP_LC) begin
						if (!byte_ok(acc_q)) begin
							r_st_q  <= ST_BADADDR;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD1;
						end
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_RD1: begin
					w1_q <= ram_rdata;
					if (op_q == OP_EXIT) begin
						r_exv_q <= ram_rdata;
						r_st_q  <= ST_EXIT;
						state_q <= S_DONE;
					end else if (op_q == OP_SI && !word_ok(ram_rdata)) begin
						r_st_q  <= ST_BADADDR;
						state_q <= S_DONE;
					end else if (op_q == OP_SC && !byte_ok(ram_rdata)) begin
						r_st_q  <= ST_BADADDR;
						state_q <= S_DONE;
					end else if (op_q == OP_SC || op_q == OP_LEV) begin
						state_q <= S_RD2;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_RD2: begin
					w2_q    <= ram_rdata;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					r_npc_q <= npc_seq;
					state_q <= S_DONE;
					case (op_q) inside
						OP_LEA:  r_acc_q <= fp_q + opd4;
						OP_IMM:  r_acc_q <= opd_q;
						OP_JMP:  r_npc_q <= opd_q;
						OP_JZ:   if (acc_q == 32'd0) r_npc_q <= opd_q;
						OP_JNZ:  if (acc_q != 32'd0) r_npc_q <= opd_q;
						OP_CALL: begin
							if (!word_ok(spm4)) begin
								r_npc_q <= ia_q;
								r_st_q  <= ST_BADADDR;
							end else begin
								r_sp_q  <= spm4;
								r_npc_q <= opd_q;
							end
						end
						OP_ENT: begin
							if (!word_ok(spm4)) begin
								r_npc_q <= ia_q;
								r_st_q  <= ST_BADADDR;
							end else begin
								r_fp_q <= spm4;
								r_sp_q <= spm4 - opd4;
							end
						end
						OP_ADJ:  r_sp_q <= sp_q + opd4;
						OP_LEV: begin
							r_sp_q  <= fp_q + 32'd8;
							r_fp_q  <= w1_q;
							r_npc_q <= w2_q;
						end
						OP_LI:   r_acc_q <= w1_q;
						OP_LC:   r_acc_q <= lc_val;
						OP_SI, OP_SC: r_sp_q <= sp_q + 32'd4;
						OP_PUSH: begin
							if (!word_ok(spm4)) begin
								r_npc_q <= ia_q;
								r_st_q  <= ST_BADADDR;
							end else begin
								r_sp_q <= spm4;
							end
						end
						OP_DIV, OP_MOD: begin
							if (acc_q == 32'd0) begin
								r_npc_q <= ia_q;
								r_st_q  <= ST_DIV0;
							end else begin
								rem_q   <= 32'd0;
								quo_q   <= w1_q[31] ? -w1_q : w1_q;
								dsr_q   <= acc_q[31] ? -acc_q : acc_q;
								qneg_q  <= w1_q[31] ^ acc_q[31];
								rneg_q  <= w1_q[31];
								cnt_q   <= 5'd0;
								state_q <= S_DIV;
							end
						end
						default: begin
							r_acc_q <= alu_res;
							r_sp_q  <= sp_q + 32'd4;
						end
					endcase
				end
				S_DIV: begin
					// One quotient bit per cycle on the magnitudes.
					if (!div_d[32]) begin
						rem_q <= div_d[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= div_t[31:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= S_DFIN;
					end
				end
				S_DFIN: begin
					if (op_q == OP_DIV) begin
						r_acc_q <= qneg_q ? -quo_q : quo_q;
					end else begin
						r_acc_q <= rneg_q ? -rem_q : rem_q;
					end
					r_sp_q  <= sp_q + 32'd4;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (commit) begin
						out_valid_q <= 1'b1;
						o_npc_q     <= r_npc_q;
						o_st_q      <= r_st_q;
						o_exv_q     <= r_exv_q;
						state_q     <= S_IDLE;
						if (r_st_q == ST_RUN) begin
							o_acc_q <= r_acc_q;
							acc_q   <= r_acc_q;
							sp_q    <= r_sp_q;
							fp_q    <= r_fp_q;
						end else begin
							o_acc_q  <= acc_q;
							halted_q <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign next_pc    = o_npc_q;
	assign acc_value  = o_acc_q;
	assign status     = o_st_q;
	assign exit_value = o_exv_q;

	// Once halted, only reset clears the flag.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared without reset");

	// A committed fault or exit must halt the block.
	a_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && r_st_q != ST_RUN) |=> halted_q)
		else $error("fault committed without halting");

	// The memory is written only by the clearing sweep or while executing.
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLR || state_q == S_EXEC))
		else $error("memory write outside sweep or execute");

	// A faulting result leaves the architectural state untouched.
	a_fault_keeps_sp: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && r_st_q != ST_RUN) |=> $stable(sp_q) && $stable(fp_q) && $stable(acc_q))
		else $error("state changed on a fault");

endmodule

FILE: verif/tb_stack_machine_instruction_executor.sv
// Self-checking testbench for stack_machine_instruction_executor: directed rows, then legal
// instruction sequences with random content, ending in one fault or exit and halted items.
// Depends on smie_pkg and the RTL top level only.
module tb_stack_machine_instruction_executor;
	import smie_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET   = 1070;
	localparam int QUIET_FROM    = 950;
	localparam int HOLD_OFF      = 300;
	localparam int WATCHDOG_MAX  = 20000;
	localparam int DRAIN_CYCLES  = 60;

	typedef struct packed {
		logic [5:0]  op;
		logic [31:0] opd;
		logic [31:0] ia;
	} instr_t;

	typedef struct packed {
		logic [31:0] npc;
		logic [31:0] acc;
		logic [2:0]  st;
		logic [31:0] ex;
	} result_t;

	typedef struct {
		instr_t  it;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [5:0]  operation;
	logic [31:0] operand;
	logic [31:0] instr_addr;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] next_pc;
	logic [31:0] acc_value;
	logic [2:0]  status;
	logic [31:0] exit_value;

	stack_machine_instruction_executor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.operand   (operand),
		.instr_addr(instr_addr),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.next_pc   (next_pc),
		.acc_value (acc_value),
		.status    (status),
		.exit_value(exit_value)
	);

	// Shadow copy of the machine: accumulator, pointers, byte memory and halt flag.
	logic [31:0] m_acc;
	logic [31:0] m_sp;
	logic [31:0] m_fp;
	logic [7:0]  m_mem [MEM_BYTES];
	bit          m_halt;

	result_t  pending_results[$];
	instr_t   upcoming_instrs[$];
	dir_row_t directed_rows[$];

	int          items_sent;
	int          results_seen;
	int          mismatches;
	int          idle_cycles;
	bit          quiet;
	bit          hold_off_done;
	logic [31:0] pc_hint;
	int          end_kind;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// ---------------------------------------------------------------------
	// Predictor helpers. Words are little endian in the byte memory.
	// ---------------------------------------------------------------------
	function automatic bit word_fits(logic [31:0] a);
		return (a[1:0] == 2'b00) && (a <= MEM_BYTES_W - 32'd4);
	endfunction

	function automatic bit byte_fits(logic [31:0] a);
		return a < MEM_BYTES_W;
	endfunction

	function automatic logic [31:0] load_word(logic [31:0] a);
		return {m_mem[a + 3], m_mem[a + 2], m_mem[a + 1], m_mem[a]};
	endfunction

	function automatic void store_word(logic [31:0] a, logic [31:0] v);
		m_mem[a]     = v[7:0];
		m_mem[a + 1] = v[15:8];
		m_mem[a + 2] = v[23:16];
		m_mem[a + 3] = v[31:24];
	endfunction

	// Executes one instruction on the shadow machine and returns the result item it gives.
	function automatic result_t execute_instr(instr_t it);
		logic [31:0] acc, sp, fp, npc, l, a, ex;
		logic [2:0]  st;
		longint      sl, sr, q;
		result_t     r;
		acc = m_acc;
		sp  = m_sp;
		fp  = m_fp;
		npc = it.ia + 32'd1;
		st  = ST_RUN;
		ex  = '0;
		l   = '0;
		if (m_halt) begin
			r = '{it.ia, m_acc, ST_HALTED, 32'd0};
			return r;
		end
		if (it.op <= OP_ADJ)
			npc = it.ia + 32'd2;
		// Binary operations take their left operand from the top of the stack.
		if (it.op >= OP_XOR && it.op <= OP_MOD) begin
			if (!word_fits(sp)) begin
				st = ST_BADADDR;
			end else begin
				l  = load_word(sp);
				sp = sp + 32'd4;
			end
		end
		if (st == ST_RUN) begin
			case (it.op) inside
				OP_LEA: acc = fp + it.opd * 32'd4;
				OP_IMM: acc = it.opd;
				OP_JMP: npc = it.opd;
				OP_JZ:  if (acc == 32'd0) npc = it.opd;
				OP_JNZ: if (acc != 32'd0) npc = it.opd;
				OP_CALL: begin
					a = sp - 32'd4;
					if (!word_fits(a)) begin
						st = ST_BADADDR;
					end else begin
						store_word(a, it.ia + 32'd2);
						sp  = a;
						npc = it.opd;
					end
				end
				OP_ENT: begin
					a = sp - 32'd4;
					if (!word_fits(a)) begin
						st = ST_BADADDR;
					end else begin
						store_word(a, fp);
						fp = a;
						sp = a - it.opd * 32'd4;
					end
				end
				OP_ADJ: sp = sp + it.opd * 32'd4;
				OP_LEV: begin
					sp = fp;
					if (!word_fits(sp) || !word_fits(sp + 32'd4)) begin
						st = ST_BADADDR;
					end else begin
						fp  = load_word(sp);
						npc = load_word(sp + 32'd4);
						sp  = sp + 32'd8;
					end
				end
				OP_LI: begin
					if (!word_fits(acc)) st = ST_BADADDR;
					else acc = load_word(acc);
				end
				OP_LC: begin
					if (!byte_fits(acc)) st = ST_BADADDR;
					else acc = {{24{m_mem[acc][7]}}, m_mem[acc]};
				end
				OP_SI, OP_SC: begin
					if (!word_fits(sp)) begin
						st = ST_BADADDR;
					end else begin
						a = load_word(sp);
						if (it.op == OP_SI) begin
							if (!word_fits(a)) st = ST_BADADDR;
							else store_word(a, acc);
						end else begin
							if (!byte_fits(a)) st = ST_BADADDR;
							else m_mem[a] = acc[7:0];
						end
						if (st == ST_RUN)
							sp = sp + 32'd4;
					end
				end
				OP_PUSH: begin
					a = sp - 32'd4;
					if (!word_fits(a)) begin
						st = ST_BADADDR;
					end else begin
						store_word(a, acc);
						sp = a;
					end
				end
				OP_XOR: acc = l ^ acc;
				OP_OR:  acc = l | acc;
				OP_AND: acc = l & acc;
				OP_EQ:  acc = (l == acc) ? 32'd1 : 32'd0;
				OP_NE:  acc = (l != acc) ? 32'd1 : 32'd0;
				OP_LT:  acc = ($signed(l) <  $signed(acc)) ? 32'd1 : 32'd0;
				OP_LE:  acc = ($signed(l) <= $signed(acc)) ? 32'd1 : 32'd0;
				OP_GT:  acc = ($signed(l) >  $signed(acc)) ? 32'd1 : 32'd0;
				OP_GE:  acc = ($signed(l) >= $signed(acc)) ? 32'd1 : 32'd0;
				OP_SHL: acc = l << acc[4:0];
				OP_SHR: acc = $signed(l) >>> acc[4:0];
				OP_ADD: acc = l + acc;
				OP_SUB: acc = l - acc;
				OP_MUL: acc = l * acc;
				OP_DIV, OP_MOD: begin
					if (acc == 32'd0) begin
						st = ST_DIV0;
					end else begin
						// 64-bit signed arithmetic keeps the minimum divided by -1 exact.
						sl  = longint'($signed(l));
						sr  = longint'($signed(acc));
						q   = (it.op == OP_DIV) ? sl / sr : sl % sr;
						acc = q[31:0];
					end
				end
				OP_EXIT: begin
					if (!word_fits(sp)) begin
						st = ST_BADADDR;
					end else begin
						ex = load_word(sp);
						st = ST_EXIT;
					end
				end
				default: st = ST_UNSUP;
			endcase
		end
		if (st != ST_RUN) begin
			m_halt = 1'b1;
			r = '{it.ia, m_acc, st, ex};
			return r;
		end
		m_acc = acc;
		m_sp  = sp;
		m_fp  = fp;
		r = '{npc, acc, ST_RUN, 32'd0};
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus generation.
	// ---------------------------------------------------------------------
	function automatic void add_row(logic [5:0] op, logic [31:0] opd, logic [31:0] ia,
			bit typed = 1'b0, logic [31:0] npc = '0, logic [31:0] acc = '0);
		dir_row_t row;
		row.it    = '{op, opd, ia};
		row.typed = typed;
		row.want  = '{npc, acc, ST_RUN, 32'd0};
		directed_rows.push_back(row);
	endfunction

	function automatic void queue_instr(logic [5:0] op, logic [31:0] opd);
		instr_t it;
		it = '{op, opd, 32'd0};
		upcoming_instrs.push_back(it);
	endfunction

	// Corner values two times in three (minimum, maximum, small values around zero, zero), else plain random words.
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($urandom_range(0, 16)) - 32'd8;
			3: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_word_addr();
		return 32'($urandom_range(0, MEM_WORDS - 1)) << 2;
	endfunction

	// Operand for ADJ that moves the stack pointer to the given aligned address.
	function automatic logic [31:0] adjust_to(logic [31:0] target);
		logic [31:0] delta;
		delta = target - m_sp;
		return {{2{delta[31]}}, delta[31:2]};
	endfunction

	// Plans the next short sequence. Each sequence is legal for the current shadow state,
	// so the machine keeps running until the closing part of the run.
	function automatic void plan_sequence();
		int          pick;
		logic [5:0]  bop;
		logic [31:0] rhs;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			queue_instr(OP_IMM, rand_word());
		end else if (pick < 16) begin
			queue_instr(OP_LEA, $urandom);
		end else if (pick < 22) begin
			queue_instr(6'(OP_JMP + 6'($urandom_range(0, 2))), rand_word());
		end else if (pick < 26 && m_sp >= 32'd256) begin
			queue_instr(OP_CALL, $urandom);
		end else if (pick < 30 && m_sp >= 32'd256) begin
			queue_instr(OP_ENT, $urandom_range(0, 8));
		end else if (pick < 34 && word_fits(m_fp) && word_fits(m_fp + 32'd4)) begin
			queue_instr(OP_LEV, $urandom);
		end else if (pick < 38) begin
			queue_instr(OP_ADJ, adjust_to(MEM_BYTES_W - 32'($urandom_range(0, 256)) * 32'd4));
		end else if (pick < 44) begin
			queue_instr(OP_IMM, rand_word_addr());
			queue_instr(OP_LI, $urandom);
		end else if (pick < 48) begin
			queue_instr(OP_IMM, $urandom_range(0, MEM_BYTES - 1));
			queue_instr(OP_LC, $urandom);
		end else if (pick < 56 && m_sp >= 32'd256) begin
			// Address goes on the stack, then the value in the accumulator is stored there.
			if ($urandom_range(0, 1) == 0) begin
				queue_instr(OP_IMM, rand_word_addr());
				queue_instr(OP_PUSH, $urandom);
				queue_instr(OP_IMM, rand_word());
				queue_instr(OP_SI, $urandom);
			end else begin
				queue_instr(OP_IMM, $urandom_range(0, MEM_BYTES - 1));
				queue_instr(OP_PUSH, $urandom);
				queue_instr(OP_IMM, rand_word());
				queue_instr(OP_SC, $urandom);
			end
		end else if (pick < 62 && m_sp >= 32'd256) begin
			queue_instr(OP_PUSH, $urandom);
		end else if (m_sp >= 32'd256) begin
			bop = 6'($urandom_range(OP_XOR, OP_MOD));
			if (word_fits(m_sp) && $urandom_range(0, 2) == 0 &&
					!(bop >= OP_DIV && m_acc == 32'd0)) begin
				// Operate on whatever is already on the stack.
				queue_instr(bop, $urandom);
			end else begin
				rhs = rand_word();
				if (bop >= OP_DIV && rhs == 32'd0)
					rhs = 32'hffff_ffff;
				queue_instr(OP_IMM, rand_word());
				queue_instr(OP_PUSH, $urandom);
				queue_instr(OP_IMM, rhs);
				queue_instr(bop, $urandom);
			end
		end else begin
			// The stack has run low: pull the pointer back towards the top of memory.
			queue_instr(OP_ADJ, adjust_to(MEM_BYTES_W - 32'($urandom_range(0, 256)) * 32'd4));
		end
	endfunction

	// The closing part: one fault or exit, chosen at random, then items the halted block
	// must answer with the halted status.
	function automatic void plan_ending();
		logic [5:0] bad_op;
		end_kind = $urandom_range(0, 3);
		case (end_kind)
			0: begin
				queue_instr(OP_ADJ, adjust_to(MEM_BYTES_W - 32'd64));
				queue_instr(OP_IMM, rand_word());
				queue_instr(OP_PUSH, $urandom);
				queue_instr(OP_EXIT, $urandom);
			end
			1: begin
				bad_op = 6'($urandom_range(30, 62));
				if (bad_op >= OP_EXIT)
					bad_op = bad_op + 6'd1;
				queue_instr(bad_op, $urandom);
			end
			2: begin
				queue_instr(OP_ADJ, adjust_to(MEM_BYTES_W - 32'd64));
				queue_instr(OP_IMM, rand_word());
				queue_instr(OP_PUSH, $urandom);
				queue_instr(OP_IMM, 32'd0);
				queue_instr($urandom_range(0, 1) ? OP_DIV : OP_MOD, $urandom);
			end
			default: begin
				queue_instr(OP_IMM, $urandom_range(0, 1) ? MEM_BYTES_W - 32'd2 : MEM_BYTES_W);
				queue_instr(OP_LI, $urandom);
			end
		endcase
		repeat (24)
			queue_instr(6'($urandom), $urandom);
	endfunction

	// ---------------------------------------------------------------------
	// Sender. Valid rises at a falling edge and is held, with its payload, until
	// the rising edge at which the block is ready.
	// ---------------------------------------------------------------------
	task automatic send_instr(instr_t it, bit typed, result_t want);
		result_t r;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(negedge clk);
		end else begin
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= it.op;
		operand    <= it.opd;
		instr_addr <= it.ia;
		do
			@(posedge clk);
		while (!in_ready);
		// Accepted at this edge: work out what the block must answer.
		r = execute_instr(it);
		pending_results.push_back(typed ? want : r);
		pc_hint = r.npc;
		items_sent++;
		if (items_sent >= QUIET_FROM)
			quiet = 1'b1;
	endtask

	task automatic send_upcoming();
		instr_t it;
		it = upcoming_instrs.pop_front();
		// Mostly follow the program counter, sometimes jump anywhere in code space.
		it.ia = ($urandom_range(0, 7) == 0) ? $urandom : pc_hint;
		send_instr(it, 1'b0, '0);
	endtask

	initial begin
		in_valid      = 1'b0;
		operation     = '0;
		operand       = '0;
		instr_addr    = '0;
		arst_n        = 1'b0;
		items_sent    = 0;
		results_seen  = 0;
		mismatches    = 0;
		quiet         = 1'b0;
		pc_hint       = '0;
		end_kind      = 0;
		m_acc         = '0;
		m_sp          = MEM_BYTES_W;
		m_fp          = MEM_BYTES_W;
		m_halt        = 1'b0;
		foreach (m_mem[i])
			m_mem[i] = 8'd0;

		// Directed rows: overflowing add, minimum divided by -1 and its remainder, a shift
		// amount above 31, sign extension of a byte load, word and byte loads and a byte store, every jump,
		// and a call with a frame, adjust and return.
		add_row(OP_IMM,  32'h7fff_ffff, 32'd0,  1'b1, 32'd2,  32'h7fff_ffff);
		add_row(OP_PUSH, 32'd0,         32'd2);
		add_row(OP_IMM,  32'd1,         32'd3);
		add_row(OP_ADD,  32'hffff_ffff, 32'd5,  1'b1, 32'd6,  32'h8000_0000);
		add_row(OP_PUSH, 32'd0,         32'd6);
		add_row(OP_IMM,  32'hffff_ffff, 32'd7);
		add_row(OP_DIV,  32'd0,         32'd9,  1'b1, 32'd10, 32'h8000_0000);
		add_row(OP_PUSH, 32'd0,         32'd10);
		add_row(OP_IMM,  32'hffff_ffff, 32'd11);
		add_row(OP_MOD,  32'd0,         32'd13, 1'b1, 32'd14, 32'd0);
		add_row(OP_IMM,  32'hffff_fff8, 32'd14);
		add_row(OP_PUSH, 32'd0,         32'd16);
		add_row(OP_IMM,  32'd33,        32'd17);
		add_row(OP_SHR,  32'd0,         32'd19, 1'b1, 32'd20, 32'hffff_fffc);
		add_row(OP_IMM,  32'h80,        32'd20);
		add_row(OP_PUSH, 32'd0,         32'd22);
		add_row(OP_IMM,  32'h1ff,       32'd23);
		add_row(OP_SC,   32'd0,         32'd25);
		add_row(OP_IMM,  32'h80,        32'd26);
		add_row(OP_LC,   32'd0,         32'd28, 1'b1, 32'd29, 32'hffff_ffff);
		add_row(OP_IMM,  32'h80,        32'd29);
		add_row(OP_LI,   32'd0,         32'd31);
		add_row(OP_LEA,  32'hffff_ffff, 32'd32);
		add_row(OP_JZ,   32'd500,       32'd33);
		add_row(OP_JNZ,  32'd500,       32'd35, 1'b1, 32'd500, MEM_BYTES_W - 32'd4);
		add_row(OP_CALL, 32'd800,       32'd500);
		add_row(OP_ENT,  32'd2,         32'd800);
		add_row(OP_ADJ,  32'hffff_ffff, 32'd802);
		add_row(OP_LEV,  32'd0,         32'd804, 1'b1, 32'd502, MEM_BYTES_W - 32'd4);
		add_row(OP_JMP,  32'hffff_ffff, 32'd502, 1'b1, 32'hffff_ffff, MEM_BYTES_W - 32'd4);

		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_instr(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
		while (items_sent < ITEM_TARGET) begin
			if (upcoming_instrs.size() == 0)
				plan_sequence();
			send_upcoming();
		end
		while (upcoming_instrs.size() != 0)
			send_upcoming();
		plan_ending();
		while (upcoming_instrs.size() != 0)
			send_upcoming();
		@(negedge clk);
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Ran %0d instructions (%0d results checked) through every opcode group,",
			items_sent, results_seen);
		$display("with frames, loads and stores, and a closing halt of kind %0d.", end_kind);
		if (mismatches == 0) begin
			$display("PASS stack_machine_instruction_executor");
		end else begin
			$display("FAIL stack_machine_instruction_executor");
		end
		$finish;
	end

	// ---------------------------------------------------------------------
	// Receiver. Random stalls, one long hold-off so that the output register fills
	// and the block stops taking items, and none once the run is in its last part.
	// ---------------------------------------------------------------------
	initial begin
		out_ready     = 1'b0;
		hold_off_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_off_done && items_sent >= 300) begin
				hold_off_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF - 1)
					@(negedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 5))
					@(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result checker: each result is matched against the oldest expectation.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result with nothing outstanding: pc %h acc %h status %0d exit %h",
						next_pc, acc_value, status, exit_value);
			end else begin
				exp_r = pending_results.pop_front();
				if (next_pc !== exp_r.npc || acc_value !== exp_r.acc ||
						status !== exp_r.st || exit_value !== exp_r.ex) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch on result %0d: expected pc %h acc %h status %0d exit %h,",
							results_seen, exp_r.npc, exp_r.acc, exp_r.st, exp_r.ex);
						$display("  got pc %h acc %h status %0d exit %h",
							next_pc, acc_value, status, exit_value);
					end
				end
			end
		end
	end

	// Watchdog: the clearing sweep after reset is the longest legal spell without traffic.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("Timed out after %0d cycles without traffic", idle_cycles);
				$display("FAIL stack_machine_instruction_executor");
				$finish;
			end
		end
	end

	initial idle_cycles = 0;

endmodule

FILE: filelist.f
src/smie_pkg.sv
src/smie_ram.sv
src/stack_machine_instruction_executor.sv
verif/tb_stack_machine_instruction_executor.sv
